// File: rtl/rlfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rlfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 7;
   localparam int CH_BITS     = 11;
   localparam int CH_IDX_W    = 4;
   localparam int KIND_W      = 3;
   localparam int ACC_W       = 18;
   localparam int NBITS_W     = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int RDY_CNT_W   = 8;

   localparam logic [BYTE_W-1:0]   SYNC_BYTE     = 8'hC8;
   localparam logic [BYTE_W-1:0]   CRC_POLY      = 8'hD5;
   localparam logic [BYTE_W-1:0]   TYPE_CHANNELS = 8'h16;
   localparam logic [BYTE_W-1:0]   TYPE_STATS    = 8'h14;
   localparam logic [BYTE_W-1:0]   MIN_LEN       = 8'd2;
   localparam logic [LEN_W-1:0]    STATS_MIN_LEN = 7'd12;
   localparam logic [LEN_W-1:0]    LQ_POS        = 7'd3;
   localparam logic [LEN_W-1:0]    RF_POS        = 7'd6;
   localparam logic [LEN_W-1:0]    TYPE_POS      = 7'd0;
   localparam logic [CH_IDX_W-1:0] AUX_FIRST_CH  = 4'd4;
   localparam logic [RDY_CNT_W-1:0] GOOD_MAX     = 8'hFF;

   localparam logic [CH_BITS-1:0]   AUX_THR_RESET   = 11'd1100;
   localparam logic [RDY_CNT_W-1:0] RDY_CNT_RESET   = 8'd131;

   localparam logic [CSR_IDX_W-1:0] CSR_AUX_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_READY_COUNT   = 2'd1;

   localparam logic [KIND_W-1:0] KIND_CHANNEL    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_STATS      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_OTHER      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_HEADER = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CRC_ERROR  = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN  = 2'd1,
      PH_BODY = 2'd2
   } parse_phase_type;

   typedef enum logic [1:0] {
      UP_IDLE = 2'd0,
      UP_READ = 2'd1,
      UP_DATA = 2'd2,
      UP_OUT  = 2'd3
   } unpack_phase_type;

   typedef struct packed {
      logic                busy;
      logic                valid;
      logic [CH_IDX_W-1:0] index;
      logic [CH_BITS-1:0]  value;
      logic                last;
   } chan_out_type;

   function automatic logic [BYTE_W-1:0] crc_next(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (c[BYTE_W-1]) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/rlfp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rlfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/rlfp_unpack.sv
`timescale 1ns / 1ps
`default_nettype none

module rlfp_unpack
   import rlfp_pkg::*;
#(
   parameter int CHANNELS = 16,
   parameter int ADDR_W   = 6
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              take,
   output logic      [ADDR_W-1:0] rd_addr,
   input  wire logic [BYTE_W-1:0] rd_data,
   output chan_out_type           stat
);

   unpack_phase_type     phase_ff, phase_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [NBITS_W-1:0]   nbits_ff, nbits_in;
   logic [ADDR_W-1:0]    ptr_ff, ptr_in;
   logic [CH_IDX_W-1:0]  ch_ff, ch_in;
   logic                 ch_last;
   logic [NBITS_W-1:0]   nbits_add;
   logic [NBITS_W-1:0]   nbits_sub;

   assign ch_last   = (ch_ff == CH_IDX_W'(CHANNELS - 1));
   assign nbits_add = nbits_ff + NBITS_W'(BYTE_W);
   assign nbits_sub = nbits_ff - NBITS_W'(CH_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= UP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      acc_ff   <= acc_in;
      nbits_ff <= nbits_in;
      ptr_ff   <= ptr_in;
      ch_ff    <= ch_in;
   end

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      nbits_in = nbits_ff;
      ptr_in   = ptr_ff;
      ch_in    = ch_ff;
      unique case (phase_ff)
         UP_IDLE: begin
            if (start) begin
               acc_in   = '0;
               nbits_in = '0;
               ptr_in   = ADDR_W'(1);
               ch_in    = '0;
               phase_in = UP_READ;
            end
         end
         UP_READ: begin
            phase_in = UP_DATA;
         end
         UP_DATA: begin
            acc_in   = acc_ff | (ACC_W'(rd_data) << nbits_ff);
            nbits_in = nbits_add;
            ptr_in   = ptr_ff + ADDR_W'(1);
            phase_in = (nbits_add >= NBITS_W'(CH_BITS)) ? UP_OUT : UP_READ;
         end
         UP_OUT: begin
            if (take) begin
               if (ch_last) begin
                  phase_in = UP_IDLE;
               end else begin
                  ch_in    = ch_ff + CH_IDX_W'(1);
                  acc_in   = acc_ff >> CH_BITS;
                  nbits_in = nbits_sub;
                  phase_in = (nbits_sub >= NBITS_W'(CH_BITS)) ? UP_OUT : UP_READ;
               end
            end
         end
         default: phase_in = UP_IDLE;
      endcase
   end

   assign rd_addr = ptr_ff;

   always_comb begin
      stat.busy  = (phase_ff != UP_IDLE);
      stat.valid = (phase_ff == UP_OUT);
      stat.index = ch_ff;
      stat.value = acc_ff[CH_BITS-1:0];
      stat.last  = ch_last;
   end

endmodule

`default_nettype wire

// File: rtl/rc_link_frame_parser_core.sv
// Parser for a sync/length/type/payload/CRC-8 serial RC link stream. One received
// byte is taken per request; bytes that complete nothing are taken every cycle
// while the channel unpacker is idle, and a byte that ends a frame or carries the
// length is also held off while the single output register still holds an unread
// response. Type and payload bytes go into a frame memory with separate write and
// read ports while the CRC-8 (poly 0xD5) runs one byte per cycle. After the CRC byte
// of a good channel frame, the input stalls while the channel unpacker walks the
// frame memory, reading each byte and then appending it to an 18-bit bit buffer, and
// gives one response per channel. Every other frame end or bad length gives a single
// response. The frame memory needs no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module rc_link_frame_parser_core
   import rlfp_pkg::*;
#(
   parameter int MAX_FRAME_LEN = 64,
   parameter int CHANNELS      = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [BYTE_W-1:0]     req_rx_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [KIND_W-1:0]     rsp_result_kind,
   output logic      [CH_IDX_W-1:0]   rsp_channel_index,
   output logic      [CH_BITS-1:0]    rsp_channel_value,
   output logic                       rsp_aux_high,
   output logic      [BYTE_W-1:0]     rsp_frame_type,
   output logic      [BYTE_W-1:0]     rsp_link_quality,
   output logic      [BYTE_W-1:0]     rsp_radio_mode,
   output logic                       rsp_link_ready,
   output logic                       rsp_bind_active,
   output logic                       rsp_last,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W   = $clog2(MAX_FRAME_LEN);
   localparam int CH_BYTES = (CHANNELS * CH_BITS + 7) / 8;

   parse_phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0]       frame_len_ff, frame_len_in;
   logic [LEN_W-1:0]       byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0]      crc_ff, crc_in;
   logic [BYTE_W-1:0]      type_ff, type_in;
   logic [BYTE_W-1:0]      lq_ff, lq_in;
   logic [BYTE_W-1:0]      rf_ff, rf_in;
   logic [RDY_CNT_W-1:0]   good_ff, good_in;
   logic                   ready_ff, ready_in;
   logic                   bind_ff, bind_in;
   logic [CH_BITS-1:0]     aux_thr_ff;
   logic [RDY_CNT_W-1:0]   rdy_cnt_ff;

   logic                   rsp_valid_ff;
   logic [KIND_W-1:0]      kind_ff, kind_in;
   logic [CH_IDX_W-1:0]    idx_ff, idx_in;
   logic [CH_BITS-1:0]     val_ff, val_in;
   logic                   aux_ff, aux_in;
   logic [BYTE_W-1:0]      otype_ff, otype_in;
   logic [BYTE_W-1:0]      olq_ff, olq_in;
   logic [BYTE_W-1:0]      orf_ff, orf_in;
   logic                   ordy_ff, ordy_in;
   logic                   obind_ff, obind_in;
   logic                   olast_ff, olast_in;
   logic                   res_load;

   logic                   req_accept;
   logic                   out_free;
   logic                   body_more;
   logic                   may_respond;
   logic                   wr_en;
   logic                   up_start;
   logic                   up_take;
   logic [ADDR_W-1:0]      rd_addr;
   logic [BYTE_W-1:0]      rd_data;
   logic [RDY_CNT_W-1:0]   good_inc;
   chan_out_type           up_stat;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign body_more   = (LEN_W'(byte_count_ff + LEN_W'(1)) < frame_len_ff);
   assign may_respond = (phase_ff == PH_LEN) || ((phase_ff == PH_BODY) && !body_more);
   assign req_stall   = up_stat.busy || (may_respond && !out_free);
   assign req_accept  = req_valid && !req_stall;
   assign up_take     = up_stat.valid && out_free;
   assign good_inc    = (good_ff == GOOD_MAX) ? good_ff : good_ff + RDY_CNT_W'(1);

   rlfp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_FRAME_LEN)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (byte_count_ff[ADDR_W-1:0]),
      .wr_data (req_rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rlfp_unpack #(
      .CHANNELS (CHANNELS),
      .ADDR_W   (ADDR_W)
   ) u_unpack (
      .clock   (clock),
      .reset   (reset),
      .start   (up_start),
      .take    (up_take),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (up_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         frame_len_ff  <= '0;
         byte_count_ff <= '0;
         crc_ff        <= '0;
         good_ff       <= '0;
         ready_ff      <= 1'b0;
         bind_ff       <= 1'b1;
         aux_thr_ff    <= AUX_THR_RESET;
         rdy_cnt_ff    <= RDY_CNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         frame_len_ff  <= frame_len_in;
         byte_count_ff <= byte_count_in;
         crc_ff        <= crc_in;
         good_ff       <= good_in;
         ready_ff      <= ready_in;
         bind_ff       <= bind_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_AUX_THRESHOLD: aux_thr_ff <= csr_wdata;
               CSR_READY_COUNT:   rdy_cnt_ff <= csr_wdata[RDY_CNT_W-1:0];
               default: ;
            endcase
         end
         if (out_free) begin
            rsp_valid_ff <= res_load;
         end
      end
      type_ff <= type_in;
      lq_ff   <= lq_in;
      rf_ff   <= rf_in;
      if (out_free && res_load) begin
         kind_ff  <= kind_in;
         idx_ff   <= idx_in;
         val_ff   <= val_in;
         aux_ff   <= aux_in;
         otype_ff <= otype_in;
         olq_ff   <= olq_in;
         orf_ff   <= orf_in;
         ordy_ff  <= ordy_in;
         obind_ff <= obind_in;
         olast_ff <= olast_in;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      frame_len_in  = frame_len_ff;
      byte_count_in = byte_count_ff;
      crc_in        = crc_ff;
      type_in       = type_ff;
      lq_in         = lq_ff;
      rf_in         = rf_ff;
      good_in       = good_ff;
      ready_in      = ready_ff;
      bind_in       = bind_ff;
      wr_en         = 1'b0;
      up_start      = 1'b0;
      res_load      = 1'b0;
      kind_in       = KIND_OTHER;
      idx_in        = '0;
      val_in        = '0;
      aux_in        = 1'b0;
      otype_in      = '0;
      olq_in        = '0;
      orf_in        = '0;
      ordy_in       = ready_ff;
      obind_in      = !ready_ff;
      olast_in      = 1'b1;

      if (up_stat.valid) begin
         res_load = 1'b1;
         kind_in  = KIND_CHANNEL;
         idx_in   = up_stat.index;
         val_in   = up_stat.value;
         aux_in   = (up_stat.index >= AUX_FIRST_CH) && (up_stat.value > aux_thr_ff);
         otype_in = type_ff;
         ordy_in  = ready_ff;
         obind_in = bind_ff;
         olast_in = up_stat.last;
      end

      if (req_accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == SYNC_BYTE) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               if ((req_rx_byte > BYTE_W'(MAX_FRAME_LEN)) || (req_rx_byte < MIN_LEN)) begin
                  phase_in = PH_HUNT;
                  res_load = 1'b1;
                  kind_in  = KIND_BAD_HEADER;
               end else begin
                  frame_len_in  = req_rx_byte[LEN_W-1:0];
                  byte_count_in = '0;
                  crc_in        = '0;
                  phase_in      = PH_BODY;
               end
            end
            PH_BODY: begin
               if (body_more) begin
                  wr_en         = 1'b1;
                  crc_in        = crc_next(crc_ff, req_rx_byte);
                  byte_count_in = byte_count_ff + LEN_W'(1);
                  if (byte_count_ff == TYPE_POS) type_in = req_rx_byte;
                  if (byte_count_ff == LQ_POS)   lq_in   = req_rx_byte;
                  if (byte_count_ff == RF_POS)   rf_in   = req_rx_byte;
               end else begin
                  phase_in = PH_HUNT;
                  otype_in = type_ff;
                  if (crc_ff != req_rx_byte) begin
                     res_load = 1'b1;
                     kind_in  = KIND_CRC_ERROR;
                  end else begin
                     if (good_inc > rdy_cnt_ff) begin
                        ready_in = 1'b1;
                        good_in  = rdy_cnt_ff;
                        bind_in  = 1'b0;
                     end else begin
                        good_in  = good_inc;
                        bind_in  = 1'b1;
                     end
                     ordy_in  = ready_in;
                     obind_in = bind_in;
                     if ((type_ff == TYPE_CHANNELS) &&
                         (frame_len_ff >= LEN_W'(CH_BYTES + 2))) begin
                        up_start = 1'b1;
                     end else if ((type_ff == TYPE_STATS) &&
                                  (frame_len_ff >= STATS_MIN_LEN)) begin
                        res_load = 1'b1;
                        kind_in  = KIND_STATS;
                        olq_in   = lq_ff;
                        orf_in   = rf_ff;
                     end else begin
                        res_load = 1'b1;
                        kind_in  = KIND_OTHER;
                     end
                  end
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = val_ff;
   assign rsp_aux_high      = aux_ff;
   assign rsp_frame_type    = otype_ff;
   assign rsp_link_quality  = olq_ff;
   assign rsp_radio_mode    = orf_ff;
   assign rsp_link_ready    = ordy_ff;
   assign rsp_bind_active   = obind_ff;
   assign rsp_last          = olast_ff;

   a_unpack_holds_input: assert property (@(posedge clock) disable iff (reset)
      up_stat.busy |-> req_stall)
      else $error("request accepted while channels are unpacked");

   a_body_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (byte_count_ff < frame_len_ff))
      else $error("byte count ran past frame length");

   a_channel_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_CHANNEL)) |->
         ((rsp_channel_index == '0) && (rsp_channel_value == '0) && !rsp_aux_high))
      else $error("channel fields set on a non-channel response");

   a_aux_only_upper: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_aux_high) |-> (rsp_channel_index >= AUX_FIRST_CH))
      else $error("aux bit set on a stick channel");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rlfp_pkg::*;

   localparam int FRAME_LEN_MAX = 64;
   localparam int CHANNEL_COUNT = 16;
   localparam int CHAN_PAYLOAD  = (CHANNEL_COUNT * CH_BITS + 7) / 8;
   localparam int STATS_PAYLOAD = 10;
   localparam int DRAIN_CYCLES  = 150;
   localparam int CYCLE_LIMIT   = 200000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CH_IDX_W-1:0] index;
      logic [CH_BITS-1:0]  value;
      logic                aux;
      logic [BYTE_W-1:0]   ftype;
      logic [BYTE_W-1:0]   lq;
      logic [BYTE_W-1:0]   rf;
      logic                rdy;
      logic                bind_on;
      logic                last;
   } link_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_W-1:0]     rsp_result_kind;
   logic [CH_IDX_W-1:0]   rsp_channel_index;
   logic [CH_BITS-1:0]    rsp_channel_value;
   logic                  rsp_aux_high;
   logic [BYTE_W-1:0]     rsp_frame_type;
   logic [BYTE_W-1:0]     rsp_link_quality;
   logic [BYTE_W-1:0]     rsp_radio_mode;
   logic                  rsp_link_ready;
   logic                  rsp_bind_active;
   logic                  rsp_last;
   logic                  csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   logic [BYTE_W-1:0] stream_bytes[$];
   link_result_type   parsed_results[$];
   link_result_type   head_result;
   int unsigned       bytes_loaded = 0;
   int unsigned       bytes_taken = 0;
   int unsigned       idle_pct = 37;
   int                fault_count = 0;
   int                cycle_count = 0;

   // parser model state
   parse_phase_type    link_phase = PH_HUNT;
   int                 frame_len = 0;
   int                 body_cnt = 0;
   logic [BYTE_W-1:0]  crc_run = '0;
   logic [BYTE_W-1:0]  frame_bytes[0:FRAME_LEN_MAX-1];
   logic [7:0]         good_cnt = '0;
   logic               ready_seen = 1'b0;
   logic [CH_BITS-1:0] aux_limit = AUX_THR_RESET;
   logic [7:0]         ready_limit = RDY_CNT_RESET;

   rc_link_frame_parser_core #(
      .MAX_FRAME_LEN(FRAME_LEN_MAX),
      .CHANNELS     (CHANNEL_COUNT)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_channel_index(rsp_channel_index),
      .rsp_channel_value(rsp_channel_value),
      .rsp_aux_high     (rsp_aux_high),
      .rsp_frame_type   (rsp_frame_type),
      .rsp_link_quality (rsp_link_quality),
      .rsp_radio_mode   (rsp_radio_mode),
      .rsp_link_ready   (rsp_link_ready),
      .rsp_bind_active  (rsp_bind_active),
      .rsp_last         (rsp_last),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] crc8_d5(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] r;
      int         k;
      r = acc ^ data;
      for (k = 0; k < 8; k++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ CRC_POLY) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   function automatic void push_result(input logic [KIND_W-1:0] kind,
                                       input int idx, input logic [CH_BITS-1:0] val,
                                       input logic aux, input logic [7:0] ftype,
                                       input logic [7:0] lq, input logic [7:0] rf,
                                       input logic bind_on, input logic last);
      link_result_type r;
      r.kind    = kind;
      r.index   = CH_IDX_W'(idx);
      r.value   = val;
      r.aux     = aux;
      r.ftype   = ftype;
      r.lq      = lq;
      r.rf      = rf;
      r.rdy     = ready_seen;
      r.bind_on = bind_on;
      r.last    = last;
      parsed_results.push_back(r);
   endfunction

   task automatic parse_byte(input logic [7:0] b);
      int                 plen;
      int                 k;
      int                 j;
      int                 pos;
      logic [CH_BITS-1:0] v;
      logic               bind_on;
      logic [7:0]         ftype;
      case (link_phase)
         PH_HUNT: begin
            if (b == SYNC_BYTE) link_phase = PH_LEN;
         end
         PH_LEN: begin
            if (int'(b) > FRAME_LEN_MAX || b < MIN_LEN) begin
               link_phase = PH_HUNT;
               push_result(KIND_BAD_HEADER, 0, '0, 1'b0, '0, '0, '0, !ready_seen, 1'b1);
            end else begin
               frame_len  = int'(b);
               body_cnt   = 0;
               crc_run    = '0;
               link_phase = PH_BODY;
            end
         end
         default: begin
            if (body_cnt + 1 < frame_len) begin
               frame_bytes[body_cnt] = b;
               crc_run = crc8_d5(crc_run, b);
               body_cnt++;
            end else begin
               link_phase = PH_HUNT;
               ftype = frame_bytes[TYPE_POS];
               plen  = frame_len - 2;
               if (crc_run != b) begin
                  push_result(KIND_CRC_ERROR, 0, '0, 1'b0, ftype, '0, '0, !ready_seen, 1'b1);
               end else begin
                  if (good_cnt != GOOD_MAX) good_cnt++;
                  if (good_cnt > ready_limit) begin
                     ready_seen = 1'b1;
                     good_cnt   = ready_limit;
                     bind_on    = 1'b0;
                  end else begin
                     bind_on = 1'b1;
                  end
                  if (ftype == TYPE_CHANNELS && plen >= CHAN_PAYLOAD) begin
                     for (k = 0; k < CHANNEL_COUNT; k++) begin
                        for (j = 0; j < CH_BITS; j++) begin
                           pos  = k * CH_BITS + j;
                           v[j] = frame_bytes[1 + pos / 8][pos % 8];
                        end
                        push_result(KIND_CHANNEL, k, v, (k >= AUX_FIRST_CH) && (v > aux_limit),
                                    ftype, '0, '0, bind_on, k == CHANNEL_COUNT - 1);
                     end
                  end else if (ftype == TYPE_STATS && plen >= STATS_PAYLOAD) begin
                     push_result(KIND_STATS, 0, '0, 1'b0, ftype, frame_bytes[LQ_POS],
                                 frame_bytes[RF_POS], bind_on, 1'b1);
                  end else begin
                     push_result(KIND_OTHER, 0, '0, 1'b0, ftype, '0, '0, bind_on, 1'b1);
                  end
               end
            end
         end
      endcase
   endtask

   task automatic load_byte(input logic [7:0] b);
      stream_bytes.push_back(b);
      bytes_loaded++;
   endtask

   // fill: 0 random with stray syncs, 1 zeros, 2 ones, 3 all sync bytes
   task automatic add_frame(input logic [7:0] ftype, input int plen, input bit bad_crc,
                            input int fill);
      logic [7:0] crc;
      logic [7:0] pb;
      int         i;
      crc = crc8_d5(8'h00, ftype);
      load_byte(SYNC_BYTE);
      load_byte(8'(plen + 2));
      load_byte(ftype);
      for (i = 0; i < plen; i++) begin
         case (fill)
            1:       pb = 8'h00;
            2:       pb = 8'hFF;
            3:       pb = SYNC_BYTE;
            default: pb = ($urandom_range(15) == 0) ? SYNC_BYTE : 8'($urandom_range(255));
         endcase
         crc = crc8_d5(crc, pb);
         load_byte(pb);
      end
      if (bad_crc) crc = crc ^ (8'h01 << $urandom_range(7));
      load_byte(crc);
   endtask

   task automatic add_random_frame();
      int         pick;
      int         plen;
      int         fill;
      int         n;
      logic [7:0] b;
      pick = $urandom_range(99);
      fill = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 3);
      if (pick < 35) begin
         if ($urandom_range(9) < 8) plen = CHAN_PAYLOAD;
         else if ($urandom_range(1) == 0) plen = CHAN_PAYLOAD - 1;
         else plen = $urandom_range(CHAN_PAYLOAD + 1, FRAME_LEN_MAX - 2);
         add_frame(TYPE_CHANNELS, plen, $urandom_range(9) == 0, fill);
      end else if (pick < 55) begin
         if ($urandom_range(9) < 7) plen = STATS_PAYLOAD;
         else if ($urandom_range(1) == 0) plen = $urandom_range(0, STATS_PAYLOAD - 1);
         else plen = $urandom_range(STATS_PAYLOAD + 1, FRAME_LEN_MAX - 2);
         add_frame(TYPE_STATS, plen, $urandom_range(9) == 0, fill);
      end else if (pick < 75) begin
         plen = ($urandom_range(9) < 8) ? $urandom_range(0, 6)
                                       : $urandom_range(0, FRAME_LEN_MAX - 2);
         add_frame(8'($urandom_range(255)), plen, $urandom_range(7) == 0, fill);
      end else if (pick < 85) begin
         add_frame(8'($urandom_range(255)), $urandom_range(0, 24), 1'b1, fill);
      end else if (pick < 93) begin
         load_byte(SYNC_BYTE);
         if ($urandom_range(1) == 0) load_byte(8'($urandom_range(0, 1)));
         else load_byte(8'($urandom_range(FRAME_LEN_MAX + 1, 255)));
      end else begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            b = 8'($urandom_range(255));
            if (b == SYNC_BYTE) b = ~b;
            load_byte(b);
         end
      end
   endtask

   task automatic add_random_stream(input int unsigned target);
      int unsigned start;
      start = bytes_loaded;
      while (bytes_loaded - start < target) add_random_frame();
   endtask

   task automatic settle();
      while (bytes_taken != bytes_loaded || parsed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_AUX_THRESHOLD: aux_limit = data;
         CSR_READY_COUNT:   ready_limit = data[7:0];
         default: ;
      endcase
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         fault_count++;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_rx_byte);
            bytes_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (stream_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid   <= 1'b1;
               req_rx_byte <= stream_bytes.pop_front();
            end else begin
               req_valid   <= 1'b0;
               req_rx_byte <= 8'($urandom_range(255));
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (parsed_results.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, got kind %0d",
                        $time, rsp_result_kind);
               fault_count++;
            end else begin
               head_result = parsed_results.pop_front();
               check_field("result_kind", head_result.kind, rsp_result_kind);
               check_field("channel_index", head_result.index, rsp_channel_index);
               check_field("channel_value", head_result.value, rsp_channel_value);
               check_field("aux_high", head_result.aux, rsp_aux_high);
               check_field("frame_type", head_result.ftype, rsp_frame_type);
               check_field("link_quality", head_result.lq, rsp_link_quality);
               check_field("radio_mode", head_result.rf, rsp_radio_mode);
               check_field("link_ready", head_result.rdy, rsp_link_ready);
               check_field("bind_active", head_result.bind_on, rsp_bind_active);
               check_field("last", head_result.last, rsp_last);
            end
         end
         rsp_stall <= ($urandom_range(99) < idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[rc_link_frame_parser_core] ERROR");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: bad lengths, hunting noise, short and broken frames
      load_byte(8'h00);
      load_byte(8'hFF);
      load_byte(SYNC_BYTE);
      load_byte(8'd0);
      load_byte(SYNC_BYTE);
      load_byte(8'd1);
      load_byte(SYNC_BYTE);
      load_byte(8'(FRAME_LEN_MAX + 1));
      load_byte(SYNC_BYTE);
      load_byte(8'hFF);
      load_byte(SYNC_BYTE);
      load_byte(SYNC_BYTE);
      add_frame(8'h3A, 0, 1'b0, 0);
      add_frame(TYPE_STATS, 0, 1'b1, 0);
      add_frame(TYPE_STATS, STATS_PAYLOAD - 1, 1'b0, 3);
      add_random_stream(45);
      settle();

      // no idling on either side
      write_csr(CSR_AUX_THRESHOLD, '0);
      write_csr(CSR_READY_COUNT, CSR_DATA_W'(254));
      write_csr(CSR_UNMAPPED_HI, '1);
      idle_pct = 0;
      add_random_stream(45);
      settle();

      idle_pct = 37;
      write_csr(CSR_AUX_THRESHOLD, '1);
      write_csr(CSR_READY_COUNT, CSR_DATA_W'(1));
      add_random_stream(45);
      settle();

      write_csr(CSR_AUX_THRESHOLD, CSR_DATA_W'($urandom_range(0, 2047)));
      write_csr(CSR_READY_COUNT, CSR_DATA_W'($urandom_range(2, 254)));
      write_csr(CSR_UNMAPPED_LO, CSR_DATA_W'($urandom_range(0, 2047)));
      add_random_stream(45);
      settle();

      if (fault_count == 0) begin
         $display("[rc_link_frame_parser_core] OK");
      end else begin
         $display("[rc_link_frame_parser_core] ERROR");
      end
      $finish;
   end

endmodule
